### hw/rtl/cvg_pkg.sv
// Shared types, codes and constants of the circle vertex generator.
package cvg_pkg;

	localparam int COORD_W = 16;
	localparam int CNT_W = 7;
	localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd20;
	localparam logic [CNT_W-1:0] VCOUNT_MIN = 7'd3;

	// Number of result bits produced by the square root and the phase divider.
	localparam int ROOT_STEPS = 17;
	localparam int DIV_STEPS = 32;

	// Q30 coefficients of the odd quarter-wave sine polynomial, lowest order first.
	localparam logic [31:0] SIN_COEF [5] = '{
		32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] first_x;
		logic signed [COORD_W-1:0] first_y;
		logic signed [COORD_W-1:0] second_x;
		logic signed [COORD_W-1:0] second_y;
	} cvg_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic                      last_vertex;
	} cvg_out_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQ_SUM,
		OP_ROOT_STEP,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_ARG,
		OP_X2,
		OP_HORNER,
		OP_SIN_END,
		OP_SCALE_X,
		OP_SCALE_Y,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [2:0]       coef;
		logic             which;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] n;
		logic             last;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

### hw/rtl/cvg_ctrl.sv
// Sequencer of the circle vertex generator: issues one datapath command per cycle.
module cvg_ctrl #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [cvg_pkg::CNT_W-1:0] vcount,
	input  cvg_pkg::status_t        status,
	output cvg_pkg::cmd_t           cmd
);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_SQ_X    = 11'b000_0000_0010,
		ST_SQ_Y    = 11'b000_0000_0100,
		ST_SQ_SUM  = 11'b000_0000_1000,
		ST_ROOT    = 11'b000_0001_0000,
		ST_DIV_INIT= 11'b000_0010_0000,
		ST_DIV     = 11'b000_0100_0000,
		ST_SIN     = 11'b000_1000_0000,
		ST_SCALE_X = 11'b001_0000_0000,
		ST_SCALE_Y = 11'b010_0000_0000,
		ST_EMIT    = 11'b100_0000_0000
	} state_t;

	localparam logic [cvg_pkg::CNT_W-1:0] N_MAX = cvg_pkg::CNT_W'(MAX_VERTICES);

	state_t                      state_q, state_d;
	logic [5:0]                  cnt_q, cnt_d;
	logic                        which_q, which_d;
	logic [cvg_pkg::CNT_W-1:0]   idx_q, idx_d;
	logic [cvg_pkg::CNT_W-1:0]   n_q, n_d;
	logic [cvg_pkg::CNT_W-1:0]   n_clamp;
	logic                        last;

	always_comb begin
		if (vcount < cvg_pkg::VCOUNT_MIN) begin
			n_clamp = cvg_pkg::VCOUNT_MIN;
		end else if (vcount > N_MAX) begin
			n_clamp = N_MAX;
		end else begin
			n_clamp = vcount;
		end
	end

	assign last = (idx_q == n_q - 7'd1);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		which_d = which_q;
		idx_d = idx_q;
		n_d = n_q;
		cmd.op = cvg_pkg::OP_NOP;
		cmd.coef = 3'd0;
		cmd.which = which_q;
		cmd.idx = idx_q;
		cmd.n = n_q;
		cmd.last = last;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op = cvg_pkg::OP_LOAD;
					n_d = n_clamp;
					idx_d = '0;
					state_d = ST_SQ_X;
				end
			end
			ST_SQ_X: begin
				cmd.op = cvg_pkg::OP_SQ_X;
				state_d = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				cmd.op = cvg_pkg::OP_SQ_Y;
				state_d = ST_SQ_SUM;
			end
			ST_SQ_SUM: begin
				cmd.op = cvg_pkg::OP_SQ_SUM;
				cnt_d = '0;
				state_d = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.op = cvg_pkg::OP_ROOT_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(cvg_pkg::ROOT_STEPS - 1)) begin
					state_d = ST_DIV_INIT;
				end
			end
			ST_DIV_INIT: begin
				cmd.op = cvg_pkg::OP_DIV_INIT;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.op = cvg_pkg::OP_DIV_STEP;
				cnt_d = cnt_q + 6'd1;
				if (cnt_q == 6'(cvg_pkg::DIV_STEPS - 1)) begin
					cnt_d = '0;
					which_d = 1'b0;
					state_d = ST_SIN;
				end
			end
			ST_SIN: begin
				cnt_d = cnt_q + 6'd1;
				case (cnt_q)
					6'd0: cmd.op = cvg_pkg::OP_ARG;
					6'd1: cmd.op = cvg_pkg::OP_X2;
					6'd2, 6'd3, 6'd4, 6'd5: begin
						cmd.op = cvg_pkg::OP_HORNER;
						cmd.coef = 3'(6'd5 - cnt_q);
					end
					default: begin
						cmd.op = cvg_pkg::OP_SIN_END;
						cnt_d = '0;
						which_d = 1'b1;
						if (which_q) begin
							state_d = ST_SCALE_X;
						end
					end
				endcase
			end
			ST_SCALE_X: begin
				cmd.op = cvg_pkg::OP_SCALE_X;
				state_d = ST_SCALE_Y;
			end
			ST_SCALE_Y: begin
				cmd.op = cvg_pkg::OP_SCALE_Y;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.op = cvg_pkg::OP_EMIT;
					if (last) begin
						idx_d = '0;
						state_d = ST_IDLE;
					end else begin
						idx_d = idx_q + 7'd1;
						state_d = ST_DIV_INIT;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			which_q <= 1'b0;
			idx_q <= '0;
			n_q <= cvg_pkg::VCOUNT_MIN;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			which_q <= which_d;
			idx_q <= idx_d;
			n_q <= n_d;
		end
	end

endmodule

### hw/rtl/cvg_datapath.sv
// Datapath of the circle vertex generator: shared multiplier, root, divider, output register.
module cvg_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  cvg_pkg::cmd_t     cmd,
	output cvg_pkg::status_t  status,
	input  cvg_pkg::cvg_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output cvg_pkg::cvg_out_t out_data
);

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
		logic signed [15:0] r;
		if (v > 19'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -19'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

	logic signed [15:0] ctr_x_q, ctr_y_q;
	logic [15:0]        ax_q, ay_q;
	logic [31:0]        acc_q;
	logic [63:0]        prod_q;
	logic [33:0]        sq_q;
	logic [17:0]        rem_q;
	logic [16:0]        root_q;
	logic [6:0]         drem_q;
	logic [31:0]        low_q;
	logic [31:0]        phase_q;
	logic [30:0]        arg_q, x2_q, sf_q, cf_q;
	logic [17:0]        offx_q;
	logic               out_valid_q;
	cvg_pkg::cvg_out_t  out_q;

	logic signed [16:0] sum_x, sum_y, dx, dy;
	logic [16:0]        adx, ady;
	logic [19:0]        trial, tsub;
	logic [7:0]         dr;
	logic               dge;
	logic [30:0]        argsel, x2n, sin_cl;
	logic [31:0]        tn, sin_raw;
	logic [1:0]         quad;
	logic [30:0]        magx, magy;
	logic               negx, negy;
	logic [47:0]        rnd;
	logic [17:0]        offy;
	logic signed [18:0] vx, vy, sox, soy;
	logic [31:0]        mul_a, mul_b;
	logic [63:0]        mul_p;

	assign sum_x = 17'(in_data.first_x) + 17'(in_data.second_x);
	assign sum_y = 17'(in_data.first_y) + 17'(in_data.second_y);
	assign dx = 17'(in_data.second_x) - 17'(in_data.first_x);
	assign dy = 17'(in_data.second_y) - 17'(in_data.first_y);
	assign adx = dx[16] ? 17'(-dx) : 17'(dx);
	assign ady = dy[16] ? 17'(-dy) : 17'(dy);

	assign trial = {rem_q, sq_q[33:32]};
	assign tsub = {1'b0, root_q, 2'b01};

	assign dr = {drem_q, low_q[31]};
	assign dge = (dr >= {1'b0, cmd.n});

	assign argsel = cmd.which ? (Q30_ONE - {1'b0, phase_q[29:0]}) : {1'b0, phase_q[29:0]};
	assign x2n = prod_q[60:30];
	assign tn = cvg_pkg::SIN_COEF[cmd.coef] - prod_q[61:30];
	assign sin_raw = prod_q[61:30];
	assign sin_cl = (sin_raw > {1'b0, Q30_ONE}) ? Q30_ONE : sin_raw[30:0];

	assign quad = phase_q[31:30];
	assign magx = quad[0] ? sf_q : cf_q;
	assign magy = quad[0] ? cf_q : sf_q;
	assign negx = quad[1] ^ quad[0];
	assign negy = quad[1];

	assign rnd = prod_q[47:0] + (48'd1 << 29);
	assign offy = rnd[47:30];
	assign sox = negx ? -$signed({1'b0, offx_q}) : $signed({1'b0, offx_q});
	assign soy = negy ? -$signed({1'b0, offy}) : $signed({1'b0, offy});
	assign vx = 19'(ctr_x_q) + sox;
	assign vy = 19'(ctr_y_q) + soy;

	// Operand select of the one shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			cvg_pkg::OP_SQ_X: begin
				mul_a = 32'(ax_q);
				mul_b = 32'(ax_q);
			end
			cvg_pkg::OP_SQ_Y: begin
				mul_a = 32'(ay_q);
				mul_b = 32'(ay_q);
			end
			cvg_pkg::OP_ARG: begin
				mul_a = 32'(argsel);
				mul_b = 32'(argsel);
			end
			cvg_pkg::OP_X2: begin
				mul_a = 32'(x2n);
				mul_b = cvg_pkg::SIN_COEF[4];
			end
			cvg_pkg::OP_HORNER: begin
				mul_a = (cmd.coef == 3'd0) ? 32'(arg_q) : 32'(x2_q);
				mul_b = tn;
			end
			cvg_pkg::OP_SCALE_X: begin
				mul_a = 32'(root_q[16:1]);
				mul_b = 32'(magx);
			end
			cvg_pkg::OP_SCALE_Y: begin
				mul_a = 32'(root_q[16:1]);
				mul_b = 32'(magy);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		case (cmd.op)
			cvg_pkg::OP_LOAD: begin
				ctr_x_q <= sum_x[16:1];
				ctr_y_q <= sum_y[16:1];
				ax_q <= adx[15:0];
				ay_q <= ady[15:0];
			end
			cvg_pkg::OP_SQ_X: prod_q <= mul_p;
			cvg_pkg::OP_SQ_Y: begin
				acc_q <= prod_q[31:0];
				prod_q <= mul_p;
			end
			cvg_pkg::OP_SQ_SUM: begin
				sq_q <= 34'(acc_q) + 34'(prod_q[31:0]);
				rem_q <= '0;
				root_q <= '0;
			end
			cvg_pkg::OP_ROOT_STEP: begin
				sq_q <= sq_q << 2;
				if (trial >= tsub) begin
					rem_q <= 18'(trial - tsub);
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q <= trial[17:0];
					root_q <= {root_q[15:0], 1'b0};
				end
			end
			cvg_pkg::OP_DIV_INIT: begin
				drem_q <= cmd.idx;
				low_q <= 32'(cmd.n >> 1);
				phase_q <= '0;
			end
			cvg_pkg::OP_DIV_STEP: begin
				drem_q <= dge ? 7'(dr - {1'b0, cmd.n}) : dr[6:0];
				phase_q <= {phase_q[30:0], dge};
				low_q <= low_q << 1;
			end
			cvg_pkg::OP_ARG: begin
				arg_q <= argsel;
				prod_q <= mul_p;
			end
			cvg_pkg::OP_X2: begin
				x2_q <= x2n;
				prod_q <= mul_p;
			end
			cvg_pkg::OP_HORNER: prod_q <= mul_p;
			cvg_pkg::OP_SIN_END: begin
				if (cmd.which) begin
					cf_q <= sin_cl;
				end else begin
					sf_q <= sin_cl;
				end
			end
			cvg_pkg::OP_SCALE_X: prod_q <= mul_p;
			cvg_pkg::OP_SCALE_Y: begin
				offx_q <= offy;
				prod_q <= mul_p;
			end
			cvg_pkg::OP_EMIT: begin
				out_q.vertex_x <= sat16(vx);
				out_q.vertex_y <= sat16(vy);
				out_q.last_vertex <= cmd.last;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == cvg_pkg::OP_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

### hw/rtl/circle_vertex_generator_top.sv
// Top level of the circle vertex generator: config register, sequencer and datapath.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | in_data  (two diameter ends)
//  out     | output    | out_valid/out_stall| out_data (vertex, last flag)
//  cfg     | input     | cfg_wr_en          | cfg_wr_data (vertex count)
//
// One input transaction yields n output transactions, n the clamped vertex count.
// Setup runs load, two squares, sum and 17 root steps; each vertex then runs
// divider setup, 32 phase divider steps, 14 sine steps,
// two scale products and emit, a sequence
// set by the single shared multiplier and the one-bit-per-cycle divider.
// Reset clears the sequencer and the output valid and loads the count 20.
// A stalled vertex holds the sequencer in its emit step; input stalls until the run ends.
module circle_vertex_generator_top #(
	parameter int MAX_VERTICES = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  cvg_pkg::cvg_in_t          in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output cvg_pkg::cvg_out_t         out_data,
	input  logic                      cfg_wr_en,
	input  logic [cvg_pkg::CNT_W-1:0] cfg_wr_data
);

	logic [cvg_pkg::CNT_W-1:0] vcount_q;
	cvg_pkg::cmd_t             cmd;
	cvg_pkg::status_t          status;

	// Hold the vertex count; the user must write it only while idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= cvg_pkg::VCOUNT_RESET;
		end else if (cfg_wr_en) begin
			vcount_q <= cfg_wr_data;
		end
	end

	cvg_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.vcount   (vcount_q),
		.status   (status),
		.cmd      (cmd)
	);

	cvg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### hw/rtl/cvg_checker.sv
// Port-level checks of the circle vertex generator, bound to the top level.
module cvg_port_checks (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input cvg_pkg::cvg_in_t          in_data,
	input logic                      out_valid,
	input logic                      out_stall,
	input cvg_pkg::cvg_out_t         out_data,
	input logic                      cfg_wr_en
);

	// A stalled vertex stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled vertex changed");

	// An accepted circle keeps the input side busy.
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// No vertex is ready in the cycle after one is taken.
	a_out_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall |=> !out_valid)
		else $error("vertex produced too early");

	// A stalled circle stays put.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("stalled circle changed");

	// Count writes land only while the sequencer is idle.
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> !in_stall)
		else $error("count written during a run");

endmodule

bind circle_vertex_generator_top cvg_port_checks u_cvg_checker (.*);

### sim/cvg_checker.sv
// Checker for the circle vertex generator: predicts each vertex run and compares.
module cvg_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  cvg_pkg::cvg_in_t          in_data,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  cvg_pkg::cvg_out_t         out_data,
	input  logic                      cfg_wr_en,
	input  logic [cvg_pkg::CNT_W-1:0] cfg_wr_data,
	output int                        fail_count,
	output int                        pending
);

	localparam longint unsigned Q30 = 64'd1 << 30;
	localparam int MAX_N = 64;

	cvg_pkg::cvg_out_t vertex_q[$];
	logic [cvg_pkg::CNT_W-1:0] vertex_count;

	assign pending = vertex_q.size();

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bit_w;
		res = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > v) bit_w >>= 2;
		while (bit_w != 0) begin
			if (v >= res + bit_w) begin
				v -= res + bit_w;
				res = (res >> 1) + bit_w;
			end else begin
				res >>= 1;
			end
			bit_w >>= 2;
		end
		return res;
	endfunction

	// sin(pi/2 * f), f and result in Q30
	function automatic longint unsigned quarter_sine(longint unsigned f);
		longint unsigned x2;
		longint unsigned t;
		x2 = (f * f) >> 30;
		t = cvg_pkg::SIN_COEF[4];
		for (int k = 3; k >= 0; k--)
			t = longint'(cvg_pkg::SIN_COEF[k]) - ((x2 * t) >> 30);
		t = (f * t) >> 30;
		return (t > Q30) ? Q30 : t;
	endfunction

	function automatic logic signed [cvg_pkg::COORD_W-1:0] clip(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[cvg_pkg::COORD_W-1:0];
	endfunction

	function automatic void predict_circle(cvg_pkg::cvg_in_t d);
		longint cx, cy, ox, oy;
		longint unsigned ax, ay, rad, n, phase, f, sf, cf, mx, my;
		logic [1:0] quad;
		cvg_pkg::cvg_out_t v;
		n = vertex_count;
		if (n < cvg_pkg::VCOUNT_MIN) n = cvg_pkg::VCOUNT_MIN;
		if (n > MAX_N) n = MAX_N;
		cx = (longint'(d.first_x) + longint'(d.second_x)) >>> 1;
		cy = (longint'(d.first_y) + longint'(d.second_y)) >>> 1;
		ox = longint'(d.second_x) - longint'(d.first_x);
		oy = longint'(d.second_y) - longint'(d.first_y);
		ax = (ox < 0) ? -ox : ox;
		ay = (oy < 0) ? -oy : oy;
		rad = int_sqrt(ax * ax + ay * ay) >> 1;
		for (longint unsigned i = 0; i < n; i++) begin
			phase = ((i << 32) + n / 2) / n;
			quad = phase[31:30];
			f = phase & (Q30 - 1);
			sf = quarter_sine(f);
			cf = quarter_sine(Q30 - f);
			// pick magnitudes per quadrant, signs follow
			mx = quad[0] ? sf : cf;
			my = quad[0] ? cf : sf;
			ox = longint'((rad * mx + (64'd1 << 29)) >> 30);
			oy = longint'((rad * my + (64'd1 << 29)) >> 30);
			if (quad == 2'd1 || quad == 2'd2) ox = -ox;
			if (quad == 2'd2 || quad == 2'd3) oy = -oy;
			v.vertex_x = clip(cx + ox);
			v.vertex_y = clip(cy + oy);
			v.last_vertex = (i == n - 1);
			vertex_q.push_back(v);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cvg_pkg::cvg_out_t want;
		if (!arst_n) begin
			vertex_q.delete();
			vertex_count <= cvg_pkg::VCOUNT_RESET;
			fail_count <= 0;
		end else begin
			if (cfg_wr_en) vertex_count <= cfg_wr_data;
			if (in_valid && !in_stall) predict_circle(in_data);
			if (out_valid && !out_stall) begin
				if (vertex_q.size() == 0) begin
					$error("unexpected vertex x=%0d y=%0d", out_data.vertex_x, out_data.vertex_y);
					fail_count <= fail_count + 1;
				end else begin
					want = vertex_q.pop_front();
					if (out_data !== want) begin
						if (out_data.vertex_x !== want.vertex_x)
							$error("vertex_x expected %0d got %0d", want.vertex_x,
								out_data.vertex_x);
						if (out_data.vertex_y !== want.vertex_y)
							$error("vertex_y expected %0d got %0d", want.vertex_y,
								out_data.vertex_y);
						if (out_data.last_vertex !== want.last_vertex)
							$error("last_vertex expected %0d got %0d", want.last_vertex,
								out_data.last_vertex);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

### sim/circle_vertex_generator_top_tb.sv
// Testbench top for the circle vertex generator: stimulus, stalls and verdict.
module circle_vertex_generator_top_tb;

	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	cvg_pkg::cvg_in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	cvg_pkg::cvg_out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [cvg_pkg::CNT_W-1:0] cfg_wr_data = '0;
	int fail_count;
	int pending;
	longint cycles = 0;
	int sent = 0;
	int burst_left = 0;

	circle_vertex_generator_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	cvg_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// Receiver stall: switch at random between no stall, light and heavy stall.
	int stall_mode = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			default: out_stall <= ($urandom_range(0, 9) < 7);
		endcase
	end

	// Watchdog: end the run if the block hangs.
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Send one transaction; hold valid and payload until accepted, then maybe leave a gap.
	task automatic send_circle(cvg_pkg::cvg_in_t d, bit force_gap);
		int gap;
		in_data <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sent++;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
		end else begin
			burst_left--;
		end
		if (force_gap && gap == 0) gap = 1;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic cvg_pkg::cvg_in_t make_circle(int ax, int ay, int bx, int by);
		cvg_pkg::cvg_in_t d;
		d.first_x = 16'(ax);
		d.first_y = 16'(ay);
		d.second_x = 16'(bx);
		d.second_y = 16'(by);
		return d;
	endfunction

	// Random circle: mostly full-range points, plus coincident, extreme and tiny circles.
	function automatic cvg_pkg::cvg_in_t random_circle();
		cvg_pkg::cvg_in_t d;
		int ext [3] = '{-32768, 32767, 0};
		d = cvg_pkg::cvg_in_t'({$urandom, $urandom});
		case ($urandom_range(0, 9))
			0: begin
				d.second_x = d.first_x;
				d.second_y = d.first_y;
			end
			1: d = make_circle(ext[$urandom_range(0, 2)], ext[$urandom_range(0, 2)],
				ext[$urandom_range(0, 2)], ext[$urandom_range(0, 2)]);
			2, 3: begin
				d.second_x = d.first_x + $signed(16'($urandom_range(0, 64))) - 16'sd32;
				d.second_y = d.first_y + $signed(16'($urandom_range(0, 64))) - 16'sd32;
			end
			default: ;
		endcase
		return d;
	endfunction

	// Wait until every expected vertex is out and the sequencer has settled, then write.
	task automatic set_count(logic [cvg_pkg::CNT_W-1:0] value);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		cvg_pkg::cvg_in_t directed [$];
		int counts [14] = '{3, 127, 0, 5, 64, 7, 1, 4, 2, 9, 6, 65, 3, 12};
		int per_phase;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset count: extremes, coincident points, saturation.
		directed.push_back(make_circle(0, 0, 0, 0));
		directed.push_back(make_circle(16384, -16384, 16384, -16384));
		directed.push_back(make_circle(-32768, -32768, 32767, 32767));
		directed.push_back(make_circle(32767, 32767, -32768, -32768));
		directed.push_back(make_circle(-32768, 0, 32767, 0));
		directed.push_back(make_circle(0, -32768, 0, 32767));
		directed.push_back(make_circle(32767, 32767, 32767, 32767));
		directed.push_back(make_circle(-32768, -32768, -32768, -32768));
		directed.push_back(make_circle(32767, 32767, 16384, 16384));
		directed.push_back(make_circle(-32768, -32768, -16384, -16384));
		directed.push_back(make_circle(-16384, 0, 16384, 0));
		directed.push_back(make_circle(1, 0, 0, 0));
		directed.push_back(make_circle(-1, -1, 0, 0));
		foreach (directed[i]) send_circle(directed[i], i == directed.size() - 1);

		// Random part across count settings, clamped values and both extremes among them.
		foreach (counts[p]) begin
			set_count(counts[p][cvg_pkg::CNT_W-1:0]);
			per_phase = (counts[p] >= 20) ? 5 : 24;
			for (int i = 0; i < per_phase; i++) send_circle(random_circle(), i == per_phase - 1);
		end
		set_count(cvg_pkg::VCOUNT_RESET);
		for (int i = 0; i < 3; i++) send_circle(random_circle(), i == 2);

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d circles over counts 0..127 (clamped to 3..64) in %0d cycles,", sent,
			cycles);
		$display("with random input gaps and output stalls.");
		if (fail_count == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/cvg_pkg.sv
hw/rtl/cvg_ctrl.sv
hw/rtl/cvg_datapath.sv
hw/rtl/circle_vertex_generator_top.sv
hw/rtl/cvg_checker.sv
sim/cvg_checker.sv
sim/circle_vertex_generator_top_tb.sv
